[src/ebd_pkg.sv]
// Shared types and constants for the moving-average backoff delay update block.
// Holds the register indexes, the 2^x interpolation table and the multiplier request type.
// No dependencies.
package ebd_pkg;

    localparam int MUL_STEPS = 17;
    localparam int MUL_CNT_W = 5;
    localparam int PROD_W    = 35;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] REG_DISCOUNT = 2'd0;
    localparam logic [1:0] REG_WIN_MIN  = 2'd1;
    localparam logic [1:0] REG_WIN_MAX  = 2'd2;

    localparam logic [15:0] EXP2_TAB [64] = '{
        16'd16384, 16'd16562, 16'd16743, 16'd16925, 16'd17109, 16'd17296, 16'd17484, 16'd17674,
        16'd17867, 16'd18061, 16'd18258, 16'd18457, 16'd18658, 16'd18861, 16'd19066, 16'd19274,
        16'd19484, 16'd19696, 16'd19911, 16'd20127, 16'd20347, 16'd20568, 16'd20792, 16'd21019,
        16'd21247, 16'd21479, 16'd21713, 16'd21949, 16'd22188, 16'd22430, 16'd22674, 16'd22921,
        16'd23170, 16'd23423, 16'd23678, 16'd23936, 16'd24196, 16'd24460, 16'd24726, 16'd24995,
        16'd25268, 16'd25543, 16'd25821, 16'd26102, 16'd26386, 16'd26674, 16'd26964, 16'd27258,
        16'd27554, 16'd27855, 16'd28158, 16'd28464, 16'd28774, 16'd29088, 16'd29405, 16'd29725,
        16'd30048, 16'd30376, 16'd30706, 16'd31041, 16'd31379, 16'd31720, 16'd32066, 16'd32415
    };

    localparam logic [15:0] EXP2_TOP = 16'd32768;

    // Two multipliers and two multiplicands; the product is
    // mpl_a * mcd_a + mpl_b * mcd_b.
    typedef struct packed {
        logic [16:0] mpl_a;
        logic [16:0] mpl_b;
        logic [15:0] mcd_a;
        logic [15:0] mcd_b;
    } t_mul_req;

endpackage

[src/ebd_cfg.sv]
// Configuration register file with an APB-style access port.
// Holds the discount factor and the window limits; takes the register indexes from ebd_pkg.
module ebd_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_discount_factor,
    output logic [7:0]  o_window_min,
    output logic [7:0]  o_window_max
);

    logic [15:0] r_discount;
    logic [7:0]  r_win_min;
    logic [7:0]  r_win_max;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount <= 16'd52429;
            r_win_min  <= 8'd1;
            r_win_max  <= 8'd250;
        end else if (w_wr) begin
            case (paddr[3:2])
                ebd_pkg::REG_DISCOUNT: r_discount <= pwdata[15:0];
                ebd_pkg::REG_WIN_MIN:  r_win_min  <= pwdata[7:0];
                ebd_pkg::REG_WIN_MAX:  r_win_max  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ebd_pkg::REG_DISCOUNT: prdata = {16'd0, r_discount};
            ebd_pkg::REG_WIN_MIN:  prdata = {24'd0, r_win_min};
            ebd_pkg::REG_WIN_MAX:  prdata = {24'd0, r_win_max};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_discount_factor = r_discount;
    assign o_window_min      = r_win_min;
    assign o_window_max      = r_win_max;

endmodule

[src/ebd_mul.sv]
// Bit-serial shift-add multiplier that forms the sum of two products.
// One multiplier bit per cycle; uses ebd_pkg for the request type and step count.
module ebd_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  ebd_pkg::t_mul_req         i_req,
    output logic                      o_done,
    output logic [ebd_pkg::PROD_W-1:0] o_prod
);

    logic [ebd_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [16:0]                   r_mpl_a;
    logic [16:0]                   r_mpl_b;
    logic [15:0]                   r_mcd_a;
    logic [15:0]                   r_mcd_b;
    logic [ebd_pkg::PROD_W-1:0]    r_acc;
    logic [16:0]                   w_addend;
    logic [18:0]                   w_sum;

    assign w_addend = (r_mpl_a[0] ? {1'b0, r_mcd_a} : 17'd0)
                    + (r_mpl_b[0] ? {1'b0, r_mcd_b} : 17'd0);
    assign w_sum    = {1'b0, r_acc[34:17]} + {2'b00, w_addend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= ebd_pkg::MUL_CNT_W'(ebd_pkg::MUL_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == ebd_pkg::MUL_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mpl_a <= i_req.mpl_a;
            r_mpl_b <= i_req.mpl_b;
            r_mcd_a <= i_req.mcd_a;
            r_mcd_b <= i_req.mcd_b;
            r_acc   <= '0;
        end else if (r_cnt != '0) begin
            r_mpl_a <= r_mpl_a >> 1;
            r_mpl_b <= r_mpl_b >> 1;
            r_acc   <= {w_sum, r_acc[16:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[src/ebd_div.sv]
// Restoring bit-serial divider that gives the 16-bit fraction num/den.
// One quotient bit per cycle; the numerator must be below the divisor. Uses ebd_pkg.
module ebd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic [ebd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [16:0]                   r_rem;
    logic [16:0]                   r_den;
    logic [15:0]                   r_quot;
    logic [17:0]                   w_trial;
    logic [17:0]                   w_diff;
    logic                          w_fit;

    assign w_trial = {r_rem, 1'b0};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= ebd_pkg::DIV_CNT_W'(ebd_pkg::DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == ebd_pkg::DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_fit ? w_diff[16:0] : w_trial[16:0];
            r_quot <= {r_quot[14:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[src/ebd_pow2.sv]
// Two-stage 2^x evaluator: table lookup, then linear interpolation and shift.
// Input is x+1 in unsigned Q2.16, output 2^x in Q3.14. Uses the ebd_pkg table.
module ebd_pow2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [17:0] i_u,
    output logic        o_done,
    output logic [16:0] o_pow
);

    logic        r_s1_vld;
    logic        r_done;
    logic [15:0] r_lo;
    logic [9:0]  r_diff;
    logic [9:0]  r_frac;
    logic [1:0]  r_ip;
    logic [16:0] r_pow;
    logic [5:0]  w_k;
    logic [15:0] w_lo;
    logic [15:0] w_hi;
    logic [15:0] w_diff;
    logic [19:0] w_prod;
    logic [20:0] w_rnd;
    logic [15:0] w_m;
    logic [16:0] w_m_inc;
    logic [16:0] w_pow;

    assign w_k    = i_u[15:10];
    assign w_lo   = ebd_pkg::EXP2_TAB[w_k];
    assign w_hi   = (w_k == 6'd63) ? ebd_pkg::EXP2_TOP : ebd_pkg::EXP2_TAB[w_k + 6'd1];
    assign w_diff = w_hi - w_lo;

    assign w_prod  = r_diff * r_frac;
    assign w_rnd   = {1'b0, w_prod} + 21'd512;
    assign w_m     = r_lo + {5'd0, w_rnd[20:10]};
    assign w_m_inc = {1'b0, w_m} + 17'd1;

    always_comb begin
        if (r_ip == 2'd0) begin
            w_pow = {1'b0, w_m_inc[16:1]};
        end else if (r_ip == 2'd1) begin
            w_pow = {1'b0, w_m};
        end else begin
            w_pow = {w_m, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
            r_done   <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo   <= w_lo;
            r_diff <= w_diff[9:0];
            r_frac <= i_u[9:0];
            r_ip   <= i_u[17:16];
        end
        if (r_s1_vld) begin
            r_pow <= w_pow;
        end
    end

    assign o_done = r_done;
    assign o_pow  = r_pow;

endmodule

[src/ema_backoff_delay_update.sv]
// Moving-average backoff delay update: sequencer, state and result register.
// A request is accepted only while the block is idle; each runs a 17-step serial multiply,
// a 16-step serial divide, the 2^x evaluator and a second 17-step multiply, then waits
// until the output register is free before the result is registered and it returns to idle.
// Synchronous active-low reset sets the average to 1.0, the delay to zero and
// the registers to their defaults. Depends on ebd_pkg and all ebd_* units.
module ema_backoff_delay_update #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] duplicate_count
    input  logic        s_axis_tuser,   // [0] new_record
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] delay_time, [31:16] moving_average
    output logic        m_axis_tuser,   // [0] rose
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_DIV  = 6'b000100,
        S_POW  = 6'b001000,
        S_MUL2 = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam logic [15:0] ONE_Q    = 16'(1 << FRAC_BITS);
    localparam logic [17:0] TWO_Q116 = 18'h20000;

    t_state r_state;
    logic   r_out_vld;
    logic   r_up;
    logic [15:0] r_ema;
    logic [15:0] r_delay;
    logic [15:0] r_old;
    logic [15:0] r_nv;
    logic [15:0] r_scaled;
    logic [15:0] r_out_delay;
    logic [15:0] r_out_avg;
    logic        r_out_rose;

    logic [15:0] w_disc;
    logic [7:0]  w_wmin;
    logic [7:0]  w_wmax;

    logic        w_accept;
    logic        w_out_free;
    logic [23:0] w_cq_ext;
    logic [15:0] w_cq;
    logic [15:0] w_old;

    ebd_pkg::t_mul_req w_mul_req;
    logic        w_mul_start;
    logic        w_mul_done;
    logic [ebd_pkg::PROD_W-1:0] w_prod;
    logic [16:0] w_nv_sum;
    logic [15:0] w_nv;
    logic [16:0] w_den;

    logic        w_div_start;
    logic        w_div_done;
    logic [15:0] w_quot;
    logic [17:0] w_q2;
    logic [17:0] w_u;

    logic        w_pow_start;
    logic        w_pow_done;
    logic [16:0] w_pow;

    logic [20:0] w_sc_sum;
    logic [15:0] w_sc;
    logic [23:0] w_cap_ext;
    logic [15:0] w_cap;
    logic [23:0] w_flr_ext;
    logic [15:0] w_flr;
    logic [15:0] w_new_delay;

    ebd_cfg u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_discount_factor (w_disc),
        .o_window_min      (w_wmin),
        .o_window_max      (w_wmax)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_out_vld | m_axis_tready;

    assign w_cq_ext = {16'd0, s_axis_tdata} << FRAC_BITS;
    assign w_cq     = (|w_cq_ext[23:16]) ? 16'hFFFF : w_cq_ext[15:0];
    assign w_old    = s_axis_tuser ? w_cq : r_ema;

    always_comb begin
        if (r_state == S_IDLE) begin
            w_mul_req.mpl_a = {1'b0, w_disc};
            w_mul_req.mpl_b = 17'h10000 - {1'b0, w_disc};
            w_mul_req.mcd_a = w_cq;
            w_mul_req.mcd_b = w_old;
        end else begin
            w_mul_req.mpl_a = w_pow;
            w_mul_req.mpl_b = 17'd0;
            w_mul_req.mcd_a = r_delay;
            w_mul_req.mcd_b = 16'd0;
        end
    end

    assign w_mul_start = w_accept | ((r_state == S_POW) & w_pow_done);

    ebd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_nv_sum = {1'b0, w_prod[31:16]} + {16'd0, w_prod[15]};
    assign w_nv     = ((|w_prod[34:32]) | w_nv_sum[16]) ? 16'hFFFF : w_nv_sum[15:0];
    assign w_den    = {1'b0, w_nv} + {1'b0, ONE_Q};

    assign w_div_start = (r_state == S_MUL1) & w_mul_done;

    ebd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_nv),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_q2 = {1'b0, w_quot, 1'b0};
    assign w_u  = r_up ? w_q2 : (TWO_Q116 - w_q2);

    assign w_pow_start = (r_state == S_DIV) & w_div_done;

    ebd_pow2 u_pow2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pow_start),
        .i_u     (w_u),
        .o_done  (w_pow_done),
        .o_pow   (w_pow)
    );

    assign w_sc_sum = w_prod[34:14] + {20'd0, w_prod[13]};
    assign w_sc     = (|w_sc_sum[20:16]) ? 16'hFFFF : w_sc_sum[15:0];

    assign w_cap_ext = {16'd0, w_wmax - 8'd1} << FRAC_BITS;
    assign w_cap     = (w_wmax == 8'd0) ? 16'd0 :
                       ((|w_cap_ext[23:16]) ? 16'hFFFF : w_cap_ext[15:0]);
    assign w_flr_ext = {15'd0, {1'b0, w_wmin} + 9'd1} << FRAC_BITS;
    assign w_flr     = (|w_flr_ext[23:16]) ? 16'hFFFF : w_flr_ext[15:0];

    always_comb begin
        if (r_up) begin
            w_new_delay = (r_scaled < w_cap) ? r_scaled : w_cap;
        end else begin
            w_new_delay = (r_scaled > w_flr) ? r_scaled : w_flr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_ema     <= ONE_Q;
            r_delay   <= 16'd0;
        end else begin
            if ((r_state == S_OUT) & w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld & m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser) begin
                            r_delay <= 16'd0;
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (w_mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (w_pow_done) begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (w_mul_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_delay   <= w_new_delay;
                        r_ema     <= r_nv;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old <= w_old;
        end
        if (w_div_start) begin
            r_nv <= w_nv;
            r_up <= (w_nv > r_old);
        end
        if ((r_state == S_MUL2) & w_mul_done) begin
            r_scaled <= w_sc;
        end
        if ((r_state == S_OUT) & w_out_free) begin
            r_out_delay <= w_new_delay;
            r_out_avg   <= r_nv;
            r_out_rose  <= r_up;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_avg, r_out_delay};
    assign m_axis_tuser  = r_out_rose;

endmodule
